### rtl/quaternion_arithmetic_unit_core_assert.svh
// assertion macros for the quaternion unit
`ifndef QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define QAU_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion unit check failed");

// next-cycle implication
`define QAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion unit check failed");

`endif

### rtl/qau_pkg.sv
package qau_pkg;

    localparam int Q_W        = 16;
    localparam int FRAC_W     = 12;
    localparam int PRE_W      = 22;
    localparam int PROD_W     = 32;
    localparam int SQ_W       = 31;
    localparam int HS_W       = 34;
    localparam int SUM_W      = 33;
    localparam int ROOT_W     = 17;
    localparam int RN_W       = 33;
    localparam int SQ_TRIAL_W = 35;
    localparam int QUO_W      = 16;
    localparam int INV_SHIFT  = 2 * FRAC_W;
    localparam int REM_W      = Q_W + INV_SHIFT;
    localparam int DIV_TRIAL_W = SUM_W + QUO_W;
    localparam int STEPS      = ROOT_W;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_CONJ  = 3'd3,
        OP_SCALE = 3'd4,
        OP_NORM  = 3'd5,
        OP_INV   = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SAT      = 2'd1,
        ST_ZERO_INV = 2'd2
    } status_t;

    // item state through the root / divide stages
    typedef struct packed {
        op_t                         op;
        logic [3:0][PRE_W-1:0]       pre;
        logic [SUM_W-1:0]            s;
        logic [ROOT_W-1:0]           rt;
        logic [RN_W-1:0]             rn;
        logic [3:0][REM_W-1:0]       rem;
        logic [3:0][QUO_W-1:0]       quo;
        logic [3:0]                  ovf;
        logic [3:0]                  neg;
    } pipe_t;

endpackage

### rtl/qau_in_if.sv
interface qau_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic signed [15:0] left_w;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_z;
    logic signed [15:0] right_w;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] scale_factor;

    modport source (
        output valid, operation, left_w, left_x, left_y, left_z,
               right_w, right_x, right_y, right_z, scale_factor,
        input  ready
    );
    modport sink (
        input  valid, operation, left_w, left_x, left_y, left_z,
               right_w, right_x, right_y, right_z, scale_factor,
        output ready
    );
endinterface

### rtl/qau_out_if.sv
interface qau_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] result_w;
    logic signed [15:0] result_x;
    logic signed [15:0] result_y;
    logic signed [15:0] result_z;
    logic [1:0]        status;

    modport source (
        output valid, result_w, result_x, result_y, result_z, status,
        input  ready
    );
    modport sink (
        input  valid, result_w, result_x, result_y, result_z, status,
        output ready
    );
endinterface

### rtl/qau_front.sv
module qau_front
    import qau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    qau_in_if.sink req,
    output logic   out_valid,
    input  logic   out_ready,
    output pipe_t  out_data
);

    logic signed [Q_W-1:0]    la [4];
    logic signed [Q_W-1:0]    ra [4];
    logic signed [PROD_W-1:0] hp_next [4][4];
    logic signed [PROD_W-1:0] kp_next [4];
    logic [SQ_W-1:0]          sq_next [4];
    logic signed [PRE_W-1:0]  pre1_next [4];
    logic [Q_W-1:0]           mag_next [4];
    logic [3:0]               neg_next;

    logic                     v1_reg, v2_reg, v3_reg;
    logic                     rdy1, rdy2, rdy3;

    // stage 1: products
    op_t                      op1_reg;
    logic signed [PROD_W-1:0] hp_reg [4][4];
    logic signed [PROD_W-1:0] kp_reg [4];
    logic [SQ_W-1:0]          sq_reg [4];
    logic signed [PRE_W-1:0]  pre1_reg [4];
    logic [Q_W-1:0]           mag1_reg [4];
    logic [3:0]               neg1_reg;

    // stage 2: sums
    logic signed [HS_W-1:0]   hs_next [4];
    logic signed [PRE_W-1:0]  pre2_next [4];
    logic [SUM_W-1:0]         ssum_next;
    op_t                      op2_reg;
    logic signed [HS_W-1:0]   hs_reg [4];
    logic signed [PRE_W-1:0]  pre2_reg [4];
    logic [SUM_W-1:0]         ssum_reg;
    logic [Q_W-1:0]           mag2_reg [4];
    logic [3:0]               neg2_reg;

    // stage 3: rounding and divider setup
    pipe_t                    p3_next;
    pipe_t                    p3_reg;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req.ready = rdy1;
    assign out_valid = v3_reg;
    assign out_data  = p3_reg;

    always_comb
    begin
        la[0] = req.left_w;  la[1] = req.left_x;  la[2] = req.left_y;  la[3] = req.left_z;
        ra[0] = req.right_w; ra[1] = req.right_x; ra[2] = req.right_y; ra[3] = req.right_z;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                hp_next[i][j] = PROD_W'(la[i]) * PROD_W'(ra[j]);
            end
            kp_next[i] = PROD_W'(req.scale_factor) * PROD_W'(la[i]);
            sq_next[i] = SQ_W'(PROD_W'(la[i]) * PROD_W'(la[i]));
            mag_next[i] = la[i][Q_W-1] ? (~la[i] + Q_W'(1)) : la[i];
            unique case (op_t'(req.operation))
                OP_ADD:  pre1_next[i] = PRE_W'(la[i]) + PRE_W'(ra[i]);
                OP_SUB:  pre1_next[i] = PRE_W'(la[i]) - PRE_W'(ra[i]);
                OP_CONJ: pre1_next[i] = (i == 0) ? PRE_W'(la[i]) : -PRE_W'(la[i]);
                default: pre1_next[i] = '0;
            endcase
        end
        // w keeps its sign, vector part is negated
        neg_next[0] = la[0][Q_W-1];
        for (int i = 1; i < 4; i++)
        begin
            neg_next[i] = !la[i][Q_W-1] && (la[i] != '0);
        end
    end

    always_comb
    begin
        hs_next[0] = HS_W'(hp_reg[0][0]) - HS_W'(hp_reg[1][1])
                   - HS_W'(hp_reg[2][2]) - HS_W'(hp_reg[3][3]);
        hs_next[1] = HS_W'(hp_reg[0][1]) + HS_W'(hp_reg[1][0])
                   + HS_W'(hp_reg[2][3]) - HS_W'(hp_reg[3][2]);
        hs_next[2] = HS_W'(hp_reg[0][2]) + HS_W'(hp_reg[2][0])
                   + HS_W'(hp_reg[3][1]) - HS_W'(hp_reg[1][3]);
        hs_next[3] = HS_W'(hp_reg[0][3]) + HS_W'(hp_reg[3][0])
                   + HS_W'(hp_reg[1][2]) - HS_W'(hp_reg[2][1]);
        ssum_next  = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                   + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
        for (int i = 0; i < 4; i++)
        begin
            if (op1_reg == OP_SCALE)
            begin
                pre2_next[i] = PRE_W'((kp_reg[i] + PROD_W'(1 << (FRAC_W - 1))) >>> FRAC_W);
            end
            else
            begin
                pre2_next[i] = pre1_reg[i];
            end
        end
    end

    always_comb
    begin
        p3_next.op  = op2_reg;
        p3_next.s   = ssum_reg;
        p3_next.rt  = '0;
        p3_next.rn  = RN_W'(ssum_reg);
        p3_next.quo = '0;
        p3_next.ovf = '0;
        p3_next.neg = neg2_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (op2_reg == OP_MUL)
            begin
                p3_next.pre[i] = PRE_W'((hs_reg[i] + HS_W'(1 << (FRAC_W - 1))) >>> FRAC_W);
            end
            else
            begin
                p3_next.pre[i] = pre2_reg[i];
            end
            // numerator with half the divisor folded in for rounding
            p3_next.rem[i] = {mag2_reg[i], {INV_SHIFT{1'b0}}} + REM_W'(ssum_reg >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && req.valid)
        begin
            op1_reg  <= op_t'(req.operation);
            hp_reg   <= hp_next;
            kp_reg   <= kp_next;
            sq_reg   <= sq_next;
            pre1_reg <= pre1_next;
            mag1_reg <= mag_next;
            neg1_reg <= neg_next;
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg  <= op1_reg;
            hs_reg   <= hs_next;
            pre2_reg <= pre2_next;
            ssum_reg <= ssum_next;
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            p3_reg <= p3_next;
        end
    end

endmodule

### rtl/qau_step.sv
module qau_step
    import qau_pkg::*;
#(
    parameter int BIT = STEPS - 1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  pipe_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output pipe_t out_data
);

    logic [SQ_TRIAL_W-1:0]  sq_trial;
    logic [ROOT_W-1:0]      rt_next;
    logic [RN_W-1:0]        rn_next;
    logic [DIV_TRIAL_W-1:0] d_trial;
    logic [3:0][REM_W-1:0]  rem_next;
    logic [3:0][QUO_W-1:0]  quo_next;
    logic [3:0]             ovf_next;
    pipe_t                  nxt;
    logic                   vld_reg;
    pipe_t                  data_reg;

    // one root bit: take it if 2*r*2^b + 4^b still fits in the remainder
    always_comb
    begin
        sq_trial = (SQ_TRIAL_W'(in_data.rt) << (BIT + 1)) + (SQ_TRIAL_W'(1) << (2 * BIT));
        rt_next  = in_data.rt;
        rn_next  = in_data.rn;
        if (SQ_TRIAL_W'(in_data.rn) >= sq_trial)
        begin
            rn_next      = in_data.rn - RN_W'(sq_trial);
            rt_next[BIT] = 1'b1;
        end
    end

    assign d_trial = DIV_TRIAL_W'(in_data.s) << BIT;

    if (BIT >= QUO_W) begin : g_ovf
        // quotient too large for any result: flag and leave remainder
        always_comb
        begin
            rem_next = in_data.rem;
            quo_next = in_data.quo;
            for (int i = 0; i < 4; i++)
            begin
                ovf_next[i] = in_data.ovf[i] || (DIV_TRIAL_W'(in_data.rem[i]) >= d_trial);
            end
        end
    end
    else begin : g_bit
        always_comb
        begin
            rem_next = in_data.rem;
            quo_next = in_data.quo;
            ovf_next = in_data.ovf;
            for (int i = 0; i < 4; i++)
            begin
                if (DIV_TRIAL_W'(in_data.rem[i]) >= d_trial)
                begin
                    rem_next[i]      = in_data.rem[i] - REM_W'(d_trial);
                    quo_next[i][BIT] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        nxt     = in_data;
        nxt.rt  = rt_next;
        nxt.rn  = rn_next;
        nxt.rem = rem_next;
        nxt.quo = quo_next;
        nxt.ovf = ovf_next;
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= nxt;
        end
    end

endmodule

### rtl/qau_back.sv
module qau_back
    import qau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pipe_t      in_data,
    qau_out_if.source  rsp
);

    localparam logic signed [PRE_W-1:0] Q_MAX = PRE_W'(32767);
    localparam logic signed [PRE_W-1:0] Q_MIN = PRE_W'(-32768);
    localparam logic signed [PRE_W-1:0] BIG   = PRE_W'(1) << (QUO_W + 1);

    logic [ROOT_W:0]         root_rnd;
    logic signed [PRE_W-1:0] val [4];
    logic [Q_W-1:0]          res [4];
    logic [3:0]              sat;
    logic                    zero_inv;
    status_t                 st;
    logic                    vld_reg;

    always_comb
    begin
        root_rnd = (in_data.rn > RN_W'(in_data.rt)) ? ({1'b0, in_data.rt} + 1'b1)
                                                    : {1'b0, in_data.rt};
        zero_inv = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            val[i] = '0;
        end
        unique case (in_data.op)
            OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    val[i] = $signed(in_data.pre[i]);
                end
            end
            OP_NORM:
            begin
                val[0] = PRE_W'(root_rnd);
            end
            OP_INV:
            begin
                if (in_data.s == '0)
                begin
                    zero_inv = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (in_data.ovf[i])
                        begin
                            val[i] = in_data.neg[i] ? -BIG : BIG;
                        end
                        else
                        begin
                            val[i] = in_data.neg[i] ? -PRE_W'(in_data.quo[i])
                                                    : PRE_W'(in_data.quo[i]);
                        end
                    end
                end
            end
            OP_NONE:
            begin
                zero_inv = 1'b0;
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            sat[i] = (val[i] > Q_MAX) || (val[i] < Q_MIN);
            if (val[i] > Q_MAX)
            begin
                res[i] = Q_W'(Q_MAX);
            end
            else if (val[i] < Q_MIN)
            begin
                res[i] = Q_W'(Q_MIN);
            end
            else
            begin
                res[i] = val[i][Q_W-1:0];
            end
        end
        if (zero_inv)
        begin
            st = ST_ZERO_INV;
        end
        else if (|sat)
        begin
            st = ST_SAT;
        end
        else
        begin
            st = ST_OK;
        end
    end

    assign in_ready  = !vld_reg || rsp.ready;
    assign rsp.valid = vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rsp.result_w <= res[0];
            rsp.result_x <= res[1];
            rsp.result_y <= res[2];
            rsp.result_z <= res[3];
            rsp.status   <= st;
        end
    end

endmodule

### rtl/quaternion_arithmetic_unit_core.sv
// quaternion alu: add, subtract, hamilton product, conjugate, scale, norm, inverse
// throughput: one item per cycle while the output is not stalled; 3 front stages, 17 root/divide stages, 1 output stage
// the 17 stages each resolve one root bit; every stage but the first also resolves one quotient bit for all four lanes
// reset: rst_n asynchronous active low, clears all stage valid bits; stage data registers are not reset
`include "quaternion_arithmetic_unit_core_assert.svh"

module quaternion_arithmetic_unit_core
    import qau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qau_in_if.sink    req,
    qau_out_if.source rsp
);

    // stage handshake chain between front, steps and back
    logic  pipe_valid [STEPS+1];
    logic  pipe_ready [STEPS+1];
    pipe_t pipe_data  [STEPS+1];

    // front: products, sums of products and squares, rounding, divider setup
    qau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .out_data  (pipe_data[0])
    );

    // one step per bit, most significant first; the first step also
    // catches inverse quotients that cannot fit any result
    for (genvar j = 0; j < STEPS; j++) begin : g_step
        qau_step #(
            .BIT (STEPS - 1 - j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[j]),
            .in_ready  (pipe_ready[j]),
            .in_data   (pipe_data[j]),
            .out_valid (pipe_valid[j+1]),
            .out_ready (pipe_ready[j+1]),
            .out_data  (pipe_data[j+1])
        );
    end

    // back: root rounding, quotient signs, saturation, status, output register
    qau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_valid[STEPS]),
        .in_ready (pipe_ready[STEPS]),
        .in_data  (pipe_data[STEPS]),
        .rsp      (rsp)
    );

    // input only backs up when the output holds an item that is not taken
    `QAU_ASSERT_HOLDS(a_stall_source, clk, rst_n, !req.ready, rsp.valid && !rsp.ready)

    // inverse of zero gives an all-zero quaternion
    `QAU_ASSERT_HOLDS(a_zero_inv, clk, rst_n, rsp.valid && rsp.status == ST_ZERO_INV, rsp.result_w == '0 && rsp.result_x == '0 && rsp.result_y == '0 && rsp.result_z == '0)

    // a saturated item has some component pinned at a rail
    `QAU_ASSERT_HOLDS(a_sat_rail, clk, rst_n, rsp.valid && rsp.status == ST_SAT, rsp.result_w == 16'sh7fff || rsp.result_w == -16'sh8000 || rsp.result_x == 16'sh7fff || rsp.result_x == -16'sh8000 || rsp.result_y == 16'sh7fff || rsp.result_y == -16'sh8000 || rsp.result_z == 16'sh7fff || rsp.result_z == -16'sh8000)

    // a stalled item leaving the front stays in place
    `QAU_ASSERT_NEXT(a_front_hold, clk, rst_n, pipe_valid[0] && !pipe_ready[0], pipe_valid[0] && $stable(pipe_data[0]))

endmodule

### bench/tb_quaternion_arithmetic_unit_core.sv
module tb_quaternion_arithmetic_unit_core;
    import qau_pkg::*;

    // one request item as it goes into the unit
    typedef struct {
        op_t                operation;
        logic signed [15:0] lw, lx, ly, lz;
        logic signed [15:0] rw, rx, ry, rz;
        logic signed [15:0] factor;
    } quat_req_t;

    // one result item as it comes out of the unit
    typedef struct {
        logic signed [15:0] w, x, y, z;
        status_t            status;
    } quat_rsp_t;

    localparam int N_RANDOM   = 1950;
    localparam int STALL_MAX  = 5000;   // cycles without any item moving
    localparam int DRAIN_WAIT = 40;     // quiet period after the last result is in

    logic clk;
    logic rst_n;

    qau_in_if  req ();
    qau_out_if rsp ();

    quaternion_arithmetic_unit_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    quat_req_t pending_q[$];     // items waiting to be driven
    quat_rsp_t expected_q[$];    // predicted results in order of acceptance
    int        n_sent;           // request items accepted by the unit
    int        n_popped;         // request items taken from the pending queue by the driver
    int        n_errors;
    int        idle_cycles;
    int        hold_index;       // item index at which the sender waits for a full drain
    bit        stim_ready;

    // clock, reset and known input levels from time zero
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.operation = OP_ADD;
        {req.left_w, req.left_x, req.left_y, req.left_z}     = '0;
        {req.right_w, req.right_x, req.right_y, req.right_z} = '0;
        req.scale_factor = '0;
        rsp.ready     = 1'b0;
        fork
            forever #4 clk = ~clk;
            begin
                repeat (5) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // saturate to 16 bits, flag any clipping
    function automatic logic signed [15:0] clip16(longint v, inout bit clipped);
        if (v > 32767)
        begin
            clipped = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            clipped = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // q8.24 back to q4.12, round half up (arithmetic shift gives the floor)
    function automatic longint q24_to_q12(longint v);
        return (v + 2048) >>> 12;
    endfunction

    // integer square root rounded to nearest, ties up
    function automatic longint root_nearest(longint unsigned s);
        longint unsigned r, b, n;
        r = 0;
        b = 64'd1 << 62;
        n = s;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (s - r * r > r)
            r++;
        return longint'(r);
    endfunction

    // num / den rounded to nearest, ties away from zero
    function automatic longint div_nearest(longint num, longint den);
        longint m;
        m = (num < 0) ? -num : num;
        m = (m + den / 2) / den;
        return (num < 0) ? -m : m;
    endfunction

    // expected result of one request item
    function automatic quat_rsp_t quat_alu_result(quat_req_t q);
        longint    a, b, c, d, e, f, g, h, k, s;
        longint    r[4];
        bit        clipped;
        quat_rsp_t res;
        a = q.lw; b = q.lx; c = q.ly; d = q.lz;
        e = q.rw; f = q.rx; g = q.ry; h = q.rz;
        k = q.factor;
        r = '{0, 0, 0, 0};
        clipped = 1'b0;
        res.status = ST_OK;
        s = a * a + b * b + c * c + d * d;
        case (q.operation)
            OP_ADD:
            begin
                r[0] = a + e; r[1] = b + f; r[2] = c + g; r[3] = d + h;
            end
            OP_SUB:
            begin
                r[0] = a - e; r[1] = b - f; r[2] = c - g; r[3] = d - h;
            end
            OP_MUL:
            begin
                r[0] = q24_to_q12(a * e - b * f - c * g - d * h);
                r[1] = q24_to_q12(a * f + b * e + c * h - d * g);
                r[2] = q24_to_q12(a * g + c * e + d * f - b * h);
                r[3] = q24_to_q12(a * h + d * e + b * g - c * f);
            end
            OP_CONJ:
            begin
                r[0] = a; r[1] = -b; r[2] = -c; r[3] = -d;
            end
            OP_SCALE:
            begin
                r[0] = q24_to_q12(k * a); r[1] = q24_to_q12(k * b);
                r[2] = q24_to_q12(k * c); r[3] = q24_to_q12(k * d);
            end
            OP_NORM:
                r[0] = root_nearest(s);
            OP_INV:
            begin
                if (s == 0)
                    res.status = ST_ZERO_INV;
                else
                begin
                    // conjugate scaled by 2^24 over the squared norm
                    r[0] = div_nearest(a * 16777216, s);
                    r[1] = div_nearest(-b * 16777216, s);
                    r[2] = div_nearest(-c * 16777216, s);
                    r[3] = div_nearest(-d * 16777216, s);
                end
            end
            default:
                ;
        endcase
        res.w = clip16(r[0], clipped);
        res.x = clip16(r[1], clipped);
        res.y = clip16(r[2], clipped);
        res.z = clip16(r[3], clipped);
        if (res.status == ST_OK && clipped)
            res.status = ST_SAT;
        return res;
    endfunction

    // operand values biased toward the corners of q4.12
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    3: return -16'sd1;
                    4: return 16'sd1;
                    5: return 16'sd4096;
                    default: return -16'sd4096;
                endcase
            end
            1, 2: return 16'($urandom_range(0, 8191)) - 16'sd4096;
            3: return 16'($urandom_range(0, 63)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_item(op_t op, logic signed [15:0] lw, lx, ly, lz,
                              logic signed [15:0] rw, rx, ry, rz, factor);
        quat_req_t q;
        q.operation = op;
        q.lw = lw; q.lx = lx; q.ly = ly; q.lz = lz;
        q.rw = rw; q.rx = rx; q.ry = ry; q.rz = rz;
        q.factor = factor;
        pending_q.push_back(q);
    endtask

    // stimulus: directed corners first, then random items
    initial
    begin
        quat_req_t q;
        stim_ready = 1'b0;
        // add and subtract with overflow in both directions
        queue_item(OP_ADD, 16'sh7fff, 16'sh8000, 1, -1, 16'sh7fff, 16'sh8000, 5, 3, 0);
        queue_item(OP_SUB, 16'sh7fff, 16'sh8000, 0, 0, 16'sh8000, 16'sh7fff, 0, 1, 0);
        queue_item(OP_ADD, 100, -200, 300, -400, 1, 2, 3, 4, 0);
        // hamilton product: identity, basis units, extremes
        queue_item(OP_MUL, 4096, 0, 0, 0, 1234, -567, 890, -12, 0);
        queue_item(OP_MUL, 0, 4096, 0, 0, 0, 0, 4096, 0, 0);
        queue_item(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                   16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
        queue_item(OP_MUL, 1, 1, 1, 1, 1, 1, 1, 1, 0);
        // conjugate, negating the most negative value clips
        queue_item(OP_CONJ, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 0, 0, 0, 0, 0);
        queue_item(OP_CONJ, 5, -6, 7, -8, 0, 0, 0, 0, 0);
        // scale by extremes and by a half that rounds
        queue_item(OP_SCALE, 16'sh7fff, 16'sh8000, 1, -1, 0, 0, 0, 0, 16'sh8000);
        queue_item(OP_SCALE, 3, -3, 2048, -2048, 0, 0, 0, 0, 2048);
        queue_item(OP_SCALE, 16'sh7fff, 100, 0, -100, 0, 0, 0, 0, 16'sh7fff);
        // norm: zero, unit, above full scale, small integer root
        queue_item(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_NORM, 4096, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_NORM, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0);
        queue_item(OP_NORM, 3, 4, 0, 0, 0, 0, 0, 0, 0);
        // inverse: zero quaternion, unit, tiny (clips), large, mixed
        queue_item(OP_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_INV, 4096, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_INV, 1, -1, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_INV, 16'sh8000, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_INV, 0, 16'sh8000, 16'sh7fff, 0, 0, 0, 0, 0, 0);
        queue_item(OP_INV, 2048, 2048, -2048, 2048, 0, 0, 0, 0, 0);
        // unused code
        queue_item(OP_NONE, 16'sh7fff, 1, 2, 3, 4, 5, 6, 7, 8);
        hold_index = pending_q.size() + N_RANDOM / 2;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            q.operation = op_t'($urandom_range(0, 7));
            q.lw = pick_value(); q.lx = pick_value();
            q.ly = pick_value(); q.lz = pick_value();
            q.rw = pick_value(); q.rx = pick_value();
            q.ry = pick_value(); q.rz = pick_value();
            q.factor = pick_value();
            // an inverse of the zero quaternion now and then
            if (q.operation == OP_INV && $urandom_range(0, 19) == 0)
                {q.lw, q.lx, q.ly, q.lz} = '0;
            pending_q.push_back(q);
        end
        stim_ready = 1'b1;
    end

    // idle chance in percent by phase: sender/receiver 32/67, then 67/32, then none
    function automatic int send_idle_pct();
        if (n_sent < 700)  return 32;
        if (n_sent < 1400) return 67;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_sent < 700)  return 67;
        if (n_sent < 1400) return 32;
        return 0;
    endfunction

    // driver: the next item goes out once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        quat_req_t q;
        if (!rst_n)
            req.valid <= 1'b0;
        else if (!req.valid || req.ready)
        begin
            // the hold point waits for every result in flight to drain
            if (stim_ready && pending_q.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct()
                && !(n_popped == hold_index
                     && (expected_q.size() > 0 || req.valid)))
            begin
                q = pending_q.pop_front();
                n_popped++;
                req.valid        <= 1'b1;
                req.operation    <= q.operation;
                req.left_w       <= q.lw;
                req.left_x       <= q.lx;
                req.left_y       <= q.ly;
                req.left_z       <= q.lz;
                req.right_w      <= q.rw;
                req.right_x      <= q.rx;
                req.right_y      <= q.ry;
                req.right_z      <= q.rz;
                req.scale_factor <= q.factor;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("mismatch on %s: got %0d, expected %0d (item %0d)",
                 what, got, want, n_sent);
    endtask

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        quat_req_t q;
        quat_rsp_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                q.operation = op_t'(req.operation);
                q.lw = req.left_w;  q.lx = req.left_x;
                q.ly = req.left_y;  q.lz = req.left_z;
                q.rw = req.right_w; q.rx = req.right_x;
                q.ry = req.right_y; q.rz = req.right_z;
                q.factor = req.scale_factor;
                expected_q.push_back(quat_alu_result(q));
                n_sent++;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result count", expected_q.size() + 1, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.result_w !== want.w)
                        report_mismatch("result_w", rsp.result_w, want.w);
                    if (rsp.result_x !== want.x)
                        report_mismatch("result_x", rsp.result_x, want.x);
                    if (rsp.result_y !== want.y)
                        report_mismatch("result_y", rsp.result_y, want.y);
                    if (rsp.result_z !== want.z)
                        report_mismatch("result_z", rsp.result_z, want.z);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                end
            end
        end
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("tb_quaternion_arithmetic_unit_core: done, errors");
            $finish;
        end
    end

    // end of run: all sent, all results in, then a short quiet period
    initial
    begin
        n_sent   = 0;
        n_popped = 0;
        n_errors = 0;
        idle_cycles = 0;
        wait (stim_ready);
        wait (pending_q.size() == 0);
        @(posedge clk);
        while (req.valid)
            @(posedge clk);
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("tb_quaternion_arithmetic_unit_core: done, clean");
        else
            $display("tb_quaternion_arithmetic_unit_core: done, errors");
        $finish;
    end

endmodule
